@@ hw/rtl/d2dg_pkg.sv @@
// shared types and constants for the disparity to depth gate
// no dependencies; imported by every module of the block
`default_nettype none

package d2dg_pkg;

	localparam int FX_W       = 32;
	localparam int DIST_W     = 20;
	localparam int DIV_W      = DIST_W + 1;
	localparam int DEPTH_W    = 16;
	localparam int GRAY_W     = 8;
	localparam int IDX_W      = 2;

	localparam logic [DIST_W-1:0]  DIST_OFFSET = DIST_W'(1500);
	localparam logic [GRAY_W-1:0]  GRAY_MAX    = GRAY_W'(255);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(65535);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FX_BASELINE   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_NEAR_DISTANCE = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_FAR_DISTANCE  = IDX_W'(2);

	typedef struct packed {
		logic [FX_W-1:0] upper;
		logic [FX_W-1:0] lower;
	} d2dg_bounds_t;

	// per-pixel flags carried down the cell row
	typedef struct packed {
		logic vld;
		logic in_range;
		logic zero_span;
		logic sat;
	} d2dg_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/d2dg_bounds.sv @@
// configuration registers and the sequential divider deriving the disparity bounds
// depends on d2dg_pkg
`default_nettype none

module d2dg_bounds (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [d2dg_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [d2dg_pkg::FX_W-1:0]     wr_data,
	output logic      [d2dg_pkg::FX_W-1:0]     fx_baseline,
	output d2dg_pkg::d2dg_bounds_t             bounds,
	output logic                               busy
);
	import d2dg_pkg::*;

	localparam int CNT_W = $clog2(FX_W + 1);

	logic [FX_W-1:0]   fx_q;
	logic [DIST_W-1:0] near_q;
	logic [DIST_W-1:0] far_q;
	logic              restart_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  rn_q;
	logic [DIV_W-1:0]  rf_q;
	logic [FX_W-1:0]   wn_q;
	logic [FX_W-1:0]   wf_q;
	d2dg_bounds_t      bounds_q;

	logic [DIV_W-1:0]  vn;
	logic [DIV_W-1:0]  vf;
	logic [DIV_W:0]    tn;
	logic [DIV_W:0]    tf;
	logic              gen;
	logic              gef;
	logic [DIV_W:0]    rn_nx;
	logic [DIV_W:0]    rf_nx;
	logic              cfg_wr;

	assign vn = DIV_W'(near_q) + DIV_W'(DIST_OFFSET);
	assign vf = DIV_W'(far_q) + DIV_W'(DIST_OFFSET);

	// a write to a spare index leaves a running division alone
	assign cfg_wr = wr_en &&
	                (wr_index inside {REG_FX_BASELINE, REG_NEAR_DISTANCE, REG_FAR_DISTANCE});

	// one quotient bit per cycle for both bounds
	assign tn    = {rn_q, wn_q[FX_W-1]};
	assign tf    = {rf_q, wf_q[FX_W-1]};
	assign gen   = tn >= {1'b0, vn};
	assign gef   = tf >= {1'b0, vf};
	assign rn_nx = gen ? tn - {1'b0, vn} : tn;
	assign rf_nx = gef ? tf - {1'b0, vf} : tf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q      <= '0;
			near_q    <= '0;
			far_q     <= '0;
			restart_q <= 1'b0;
			cnt_q     <= '0;
			bounds_q  <= '0;
		end else begin
			if (cfg_wr) begin
				case (wr_index)
					REG_FX_BASELINE: begin
						fx_q      <= wr_data;
						restart_q <= 1'b1;
					end
					REG_NEAR_DISTANCE: begin
						near_q    <= wr_data[DIST_W-1:0];
						restart_q <= 1'b1;
					end
					REG_FAR_DISTANCE: begin
						far_q     <= wr_data[DIST_W-1:0];
						restart_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (restart_q) begin
				restart_q <= 1'b0;
				cnt_q     <= CNT_W'(FX_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					bounds_q.upper <= {wn_q[FX_W-2:0], gen};
					bounds_q.lower <= {wf_q[FX_W-2:0], gef};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart_q) begin
			rn_q <= '0;
			rf_q <= '0;
			wn_q <= fx_q;
			wf_q <= fx_q;
		end else begin
			rn_q <= rn_nx[DIV_W-1:0];
			rf_q <= rf_nx[DIV_W-1:0];
			wn_q <= {wn_q[FX_W-2:0], gen};
			wf_q <= {wf_q[FX_W-2:0], gef};
		end
	end

	assign fx_baseline = fx_q;
	assign bounds      = bounds_q;
	assign busy        = restart_q | (cnt_q != '0);

endmodule

`default_nettype wire

@@ hw/rtl/d2dg_cell.sv @@
// one cell of the division row: a depth quotient bit and a gray quotient bit per cycle
// depends on d2dg_pkg
`default_nettype none

module d2dg_cell #(
	parameter int DISPARITY_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  d2dg_pkg::d2dg_ctl_t                up_ctl,
	input  wire logic [DISPARITY_BITS-1:0]     up_d,
	input  wire logic [DISPARITY_BITS-1:0]     up_dr,
	input  wire logic [d2dg_pkg::DEPTH_W-1:0]  up_dw,
	input  wire logic [d2dg_pkg::FX_W-1:0]     up_span,
	input  wire logic [d2dg_pkg::FX_W-1:0]     up_gr,
	input  wire logic [d2dg_pkg::DEPTH_W-1:0]  up_gw,
	output d2dg_pkg::d2dg_ctl_t                dn_ctl,
	output logic      [DISPARITY_BITS-1:0]     dn_d,
	output logic      [DISPARITY_BITS-1:0]     dn_dr,
	output logic      [d2dg_pkg::DEPTH_W-1:0]  dn_dw,
	output logic      [d2dg_pkg::FX_W-1:0]     dn_span,
	output logic      [d2dg_pkg::FX_W-1:0]     dn_gr,
	output logic      [d2dg_pkg::DEPTH_W-1:0]  dn_gw
);
	import d2dg_pkg::*;

	d2dg_ctl_t                 ctl_q;
	logic [DISPARITY_BITS-1:0] d_q;
	logic [DISPARITY_BITS-1:0] dr_q;
	logic [DEPTH_W-1:0]        dw_q;
	logic [FX_W-1:0]           span_q;
	logic [FX_W-1:0]           gr_q;
	logic [DEPTH_W-1:0]        gw_q;

	logic [DISPARITY_BITS:0]   dt;
	logic [DISPARITY_BITS:0]   dr_nx;
	logic                      dge;
	logic [FX_W:0]             gt;
	logic [FX_W:0]             gr_nx;
	logic                      gge;

	// restoring step; the partial remainder stays below the divisor
	assign dt    = {up_dr, up_dw[DEPTH_W-1]};
	assign dge   = dt >= {1'b0, up_d};
	assign dr_nx = dge ? dt - {1'b0, up_d} : dt;

	assign gt    = {up_gr, up_gw[DEPTH_W-1]};
	assign gge   = gt >= {1'b0, up_span};
	assign gr_nx = gge ? gt - {1'b0, up_span} : gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		d_q    <= up_d;
		dr_q   <= dr_nx[DISPARITY_BITS-1:0];
		dw_q   <= {up_dw[DEPTH_W-2:0], dge};
		span_q <= up_span;
		gr_q   <= gr_nx[FX_W-1:0];
		gw_q   <= {up_gw[DEPTH_W-2:0], gge};
	end

	assign dn_ctl  = ctl_q;
	assign dn_d    = d_q;
	assign dn_dr   = dr_q;
	assign dn_dw   = dw_q;
	assign dn_span = span_q;
	assign dn_gr   = gr_q;
	assign dn_gw   = gw_q;

endmodule

`default_nettype wire

@@ hw/rtl/disparity_to_depth_gate_top.sv @@
// disparity to depth gate: range check, depth division and gray shade per pixel
// depends on d2dg_pkg, d2dg_bounds, d2dg_cell
//
// usage:
//   pixels enter on start/disparity; a transaction is taken at an edge where start is
//   high and busy is low. one pixel can be taken every cycle while busy is low.
//   each result appears on gray_shade, depth_value and in_range for one cycle with done
//   high. results leave in pixel order, one per cycle.
//   the receiver cannot stall; done is never held off.
//   latency is set by the row of 16 division cells, one quotient bit per cell for both
//   fx_baseline / disparity and the gray scaling, plus an input and an output register.
//   configuration writes on wr_en/wr_index/wr_data take effect at once; the disparity
//   bounds are then derived by two radix-2 dividers that share one counter, after the
//   last write; busy stays high until they finish (and during a write cycle itself).
//   write only while no pixel is in flight.
//   after reset all registers and both bounds are zero and busy is low; no clearing pass.
`default_nettype none

module disparity_to_depth_gate_top #(
	parameter int DISPARITY_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [DISPARITY_BITS-1:0]     disparity,
	output logic                               done,
	output logic      [d2dg_pkg::GRAY_W-1:0]   gray_shade,
	output logic      [d2dg_pkg::DEPTH_W-1:0]  depth_value,
	output logic                               in_range,
	input  wire logic                          wr_en,
	input  wire logic [d2dg_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [d2dg_pkg::FX_W-1:0]     wr_data
);
	import d2dg_pkg::*;

	localparam int N_CELLS = DEPTH_W;
	localparam int CMP_W   = (DISPARITY_BITS > DEPTH_W) ? DISPARITY_BITS : DEPTH_W;

	logic [FX_W-1:0]           fx_baseline;
	d2dg_bounds_t              bounds;
	logic                      bnd_busy;

	logic                      vld_s1;
	logic [DISPARITY_BITS-1:0] d_s1;

	logic [FX_W-1:0]           d32;
	logic [FX_W-1:0]           span;
	logic [FX_W-1:0]           diff;
	logic [FX_W-1:0]           num;
	logic [DEPTH_W-1:0]        fx_hi;
	logic                      sat;

	d2dg_ctl_t                 ctl_c  [0:N_CELLS];
	logic [DISPARITY_BITS-1:0] d_c    [0:N_CELLS];
	logic [DISPARITY_BITS-1:0] dr_c   [0:N_CELLS];
	logic [DEPTH_W-1:0]        dw_c   [0:N_CELLS];
	logic [FX_W-1:0]           span_c [0:N_CELLS];
	logic [FX_W-1:0]           gr_c   [0:N_CELLS];
	logic [DEPTH_W-1:0]        gw_c   [0:N_CELLS];

	logic                      done_q;
	logic [GRAY_W-1:0]         gray_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic                      in_range_q;
	d2dg_ctl_t                 last_ctl;
	logic                      accept;

	d2dg_bounds u_bounds (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.fx_baseline (fx_baseline),
		.bounds      (bounds),
		.busy        (bnd_busy)
	);

	assign busy   = wr_en | bnd_busy;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= disparity;
	end

	// range check and division setup
	assign d32   = FX_W'(d_s1);
	assign span  = bounds.upper - bounds.lower;
	assign diff  = d32 - bounds.lower;
	assign num   = (diff << GRAY_W) - diff;
	assign fx_hi = fx_baseline[FX_W-1:DEPTH_W];
	// quotient would not fit in 16 bits, zero disparity included
	assign sat   = CMP_W'(fx_hi) >= CMP_W'(d_s1);

	assign ctl_c[0].vld       = vld_s1;
	assign ctl_c[0].in_range  = (d32 >= bounds.lower) && (d32 <= bounds.upper);
	assign ctl_c[0].zero_span = (span == '0);
	assign ctl_c[0].sat       = sat;
	assign d_c[0]    = d_s1;
	assign dr_c[0]   = sat ? '0 : DISPARITY_BITS'(fx_hi);
	assign dw_c[0]   = fx_baseline[DEPTH_W-1:0];
	assign span_c[0] = span;
	assign gr_c[0]   = FX_W'(num[FX_W-1:DEPTH_W]);
	assign gw_c[0]   = num[DEPTH_W-1:0];

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		d2dg_cell #(
			.DISPARITY_BITS (DISPARITY_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctl  (ctl_c[i]),
			.up_d    (d_c[i]),
			.up_dr   (dr_c[i]),
			.up_dw   (dw_c[i]),
			.up_span (span_c[i]),
			.up_gr   (gr_c[i]),
			.up_gw   (gw_c[i]),
			.dn_ctl  (ctl_c[i+1]),
			.dn_d    (d_c[i+1]),
			.dn_dr   (dr_c[i+1]),
			.dn_dw   (dw_c[i+1]),
			.dn_span (span_c[i+1]),
			.dn_gr   (gr_c[i+1]),
			.dn_gw   (gw_c[i+1])
		);
	end

	assign last_ctl = ctl_c[N_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		in_range_q <= last_ctl.in_range;
		if (!last_ctl.in_range) begin
			gray_q  <= '0;
			depth_q <= '0;
		end else begin
			depth_q <= last_ctl.sat ? DEPTH_MAX : dw_c[N_CELLS];
			gray_q  <= last_ctl.zero_span ? GRAY_MAX :
			           GRAY_MAX - gw_c[N_CELLS][GRAY_W-1:0];
		end
	end

	assign done        = done_q;
	assign gray_shade  = gray_q;
	assign depth_value = depth_q;
	assign in_range    = in_range_q;

endmodule

`default_nettype wire

@@ hw/rtl/disparity_to_depth_gate_checker.sv @@
// port-level checks for the disparity to depth gate, bound to the top level
// depends on d2dg_pkg and disparity_to_depth_gate_top
`default_nettype none

module disparity_to_depth_gate_checker #(
	parameter int DISPARITY_BITS = 16
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [DISPARITY_BITS-1:0] disparity,
	input wire logic                      done,
	input wire logic [7:0]                gray_shade,
	input wire logic [15:0]               depth_value,
	input wire logic                      in_range,
	input wire logic                      wr_en,
	input wire logic [1:0]                wr_index,
	input wire logic [31:0]               wr_data
);
	import d2dg_pkg::*;

	localparam int LAT = 18;

	// every transaction yields exactly one result after the fixed latency
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("transaction without result");

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without transaction");

	// rejected pixels carry zero shade and depth
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_range) |-> (gray_shade == 8'd0 && depth_value == 16'd0))
		else $error("rejected pixel with nonzero output");

	// bounds are still being derived right after a register write
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(wr_en && (wr_index == REG_FX_BASELINE || wr_index == REG_NEAR_DISTANCE ||
			wr_index == REG_FAR_DISTANCE)) |-> busy)
		else $error("not busy after configuration write");

endmodule

bind disparity_to_depth_gate_top disparity_to_depth_gate_checker #(
	.DISPARITY_BITS (DISPARITY_BITS)
) u_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for disparity_to_depth_gate_top: range gate, depth and gray shade
// depends on d2dg_pkg and the rtl of the block; a scoreboard class predicts each pixel
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import d2dg_pkg::*;

	localparam int DISP_W = 16;
	localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);
	localparam int RANDOM_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 240;

	typedef struct packed {
		logic [GRAY_W-1:0]  gray;
		logic [DEPTH_W-1:0] depth;
		logic               in_range;
	} pixel_result_t;

	// keeps a copy of the configuration and bounds, and the results still owed
	class shade_scoreboard;
		logic [FX_W-1:0]   fx_baseline;
		logic [DIST_W-1:0] near_mm;
		logic [DIST_W-1:0] far_mm;
		logic [FX_W-1:0]   upper;
		logic [FX_W-1:0]   lower;
		pixel_result_t     pending[$];
		int unsigned       failures;

		function new();
			fx_baseline = '0;
			near_mm = '0;
			far_mm = '0;
			upper = '0;
			lower = '0;
			failures = 0;
		endfunction

		function void write_register(logic [IDX_W-1:0] idx, logic [FX_W-1:0] data);
			case (idx)
				REG_FX_BASELINE: begin
					fx_baseline = data;
				end
				REG_NEAR_DISTANCE: begin
					near_mm = data[DIST_W-1:0];
				end
				REG_FAR_DISTANCE: begin
					far_mm = data[DIST_W-1:0];
				end
				default: begin
					return;
				end
			endcase
			upper = fx_baseline / (FX_W'(near_mm) + FX_W'(DIST_OFFSET));
			lower = fx_baseline / (FX_W'(far_mm) + FX_W'(DIST_OFFSET));
		endfunction

		function pixel_result_t predict_pixel(logic [DISP_W-1:0] d);
			pixel_result_t r;
			logic [63:0] dd;
			logic [63:0] q;
			r = '0;
			dd = 64'(d);
			if (dd >= 64'(lower) && dd <= 64'(upper)) begin
				r.in_range = 1'b1;
				if (dd == 0) begin
					r.depth = DEPTH_MAX;
				end else begin
					q = 64'(fx_baseline) / dd;
					r.depth = (q > 64'(DEPTH_MAX)) ? DEPTH_MAX : q[DEPTH_W-1:0];
				end
				if (upper == lower) begin
					r.gray = GRAY_MAX;
				end else begin
					q = ((dd - 64'(lower)) * 64'(GRAY_MAX)) / (64'(upper) - 64'(lower));
					r.gray = GRAY_MAX - q[GRAY_W-1:0];
				end
			end
			return r;
		endfunction

		function void note_pixel(logic [DISP_W-1:0] d);
			pending.push_back(predict_pixel(d));
		endfunction

		function void check_result(logic [GRAY_W-1:0] gray, logic [DEPTH_W-1:0] depth,
				logic inr);
			pixel_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: gray_shade %0d depth_value %0d in_range %0d",
					gray, depth, inr);
				failures++;
				return;
			end
			e = pending.pop_front();
			if (gray !== e.gray) begin
				$error("gray_shade: expected %0d, actual %0d", e.gray, gray);
				failures++;
			end
			if (depth !== e.depth) begin
				$error("depth_value: expected %0d, actual %0d", e.depth, depth);
				failures++;
			end
			if (inr !== e.in_range) begin
				$error("in_range: expected %0d, actual %0d", e.in_range, inr);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [DISP_W-1:0] disparity = '0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [FX_W-1:0] wr_data = '0;
	logic busy;
	logic done;
	logic [GRAY_W-1:0] gray_shade;
	logic [DEPTH_W-1:0] depth_value;
	logic in_range;

	shade_scoreboard book = new();

	disparity_to_depth_gate_top #(
		.DISPARITY_BITS(DISP_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.disparity(disparity),
		.done(done),
		.gray_shade(gray_shade),
		.depth_value(depth_value),
		.in_range(in_range),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// results are checked before the transaction of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				book.check_result(gray_shade, depth_value, in_range);
			if (start && !busy)
				book.note_pixel(disparity);
		end
	end

	task automatic drive_pixel(input logic [DISP_W-1:0] d);
		start <= 1'b1;
		disparity <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FX_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		book.write_register(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_pixels();
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [FX_W-1:0] fx, input logic [FX_W-1:0] near_d,
			input logic [FX_W-1:0] far_d);
		drain_pixels();
		write_reg(REG_FX_BASELINE, fx);
		write_reg(REG_NEAR_DISTANCE, near_d);
		write_reg(REG_FAR_DISTANCE, far_d);
	endtask

	task automatic drive_directed(input logic [DISP_W-1:0] list[$]);
		foreach (list[i])
			drive_pixel(list[i]);
		start <= 1'b0;
	endtask

	// mostly pixels inside or at the edges of the bounds, the rest anywhere
	function automatic logic [DISP_W-1:0] pick_disparity();
		int unsigned lo;
		int unsigned hi;
		int unsigned sel;
		lo = book.lower;
		hi = (book.upper > 32'hFFFF) ? 32'hFFFF : book.upper;
		sel = $urandom_range(0, 15);
		if (lo > hi || lo > 32'hFFFF || sel < 4)
			return DISP_W'($urandom_range(0, 16'hFFFF));
		if (sel == 4)
			return DISP_W'((lo == 0) ? 0 : lo - 1);
		if (sel == 5)
			return DISP_W'(lo);
		if (sel == 6)
			return DISP_W'(hi);
		if (sel == 7)
			return DISP_W'((hi == 32'hFFFF) ? hi : hi + 1);
		return DISP_W'($urandom_range(lo, hi));
	endfunction

	task automatic random_phase(input int count);
		logic [FX_W-1:0] fx;
		logic [DIST_W-1:0] near_d;
		logic [DIST_W-1:0] far_d;
		int n;
		int burst;
		int gap;
		bit no_gaps;
		fx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100_000_000);
		near_d = ($urandom_range(0, 7) == 0) ? DIST_W'($urandom) :
			DIST_W'($urandom_range(0, 5000));
		if ($urandom_range(0, 5) == 0)
			far_d = DIST_W'($urandom);
		else
			far_d = near_d + DIST_W'($urandom_range(0, 200_000));
		drain_pixels();
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, $urandom);
		// upper data bits of the distance registers are junk
		write_reg(REG_FAR_DISTANCE, {12'($urandom), far_d});
		write_reg(REG_FX_BASELINE, fx);
		write_reg(REG_NEAR_DISTANCE, {12'($urandom), near_d});
		no_gaps = ($urandom_range(0, 3) == 0);
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n < count; i++) begin
				drive_pixel(pick_disparity());
				n++;
			end
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: both bounds zero, only zero disparity passes
		drive_directed('{16'd0, 16'd1, 16'hFFFF});

		// ordinary bounds 591..30000, with an ignored write to the spare index
		configure(32'd60_000_000, 32'd500, 32'd100_000);
		drain_pixels();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		drive_directed('{16'd590, 16'd591, 16'd30000, 16'd30001, 16'd1000});

		// all registers at their maximum: equal bounds, zero span
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drive_directed('{16'd4089, 16'd4090, 16'd4091});

		// upper bound beyond the disparity range, depth always saturated
		configure(32'hFFFF_FFFF, 32'd0, 32'h000F_FFFF);
		drive_directed('{16'd4090, 16'hFFFF, 16'h8000});

		// lower bound zero so a zero disparity is accepted
		configure(32'd1_000_000, 32'd0, 32'h000F_FFFF);
		drive_directed('{16'd0, 16'd666, 16'd667, 16'd333});

		// crossed bounds reject everything
		configure(32'd60_000_000, 32'd100_000, 32'd500);
		drive_directed('{16'd591, 16'd30000, 16'd10000});

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(PIXELS_PER_PHASE);

		drain_pixels();
		repeat (40) @(posedge clk);
		if (book.failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/d2dg_pkg.sv
hw/rtl/d2dg_bounds.sv
hw/rtl/d2dg_cell.sv
hw/rtl/disparity_to_depth_gate_top.sv
hw/rtl/disparity_to_depth_gate_checker.sv
sim/testbench.sv
